// ===== sv/rpwt_pkg.sv =====
package rpwt_pkg;

   // Default depth of the receive bitmap, in sequence numbers.
   localparam int WINDOW_BITS_DEFAULT = 64;

   // Width of the selective-ack bitmap carried in each result.
   localparam int SACK_BITS = 64;

   localparam int PSN_W = 32;

   // Input operation codes.
   localparam logic OPCODE_PACKET  = 1'b0;
   localparam logic OPCODE_RESTART = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_NEW       = 2'd0;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;
   localparam logic [1:0] STATUS_RESTARTED = 2'd3;

   // Register map of the configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORDERED_MODE_ADDR = 3'd0;

   typedef struct packed {
      logic             opcode;
      logic [PSN_W-1:0] psn;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [PSN_W-1:0]     cumulative_psn;
      logic [PSN_W-1:0]     expected_psn;
      logic [PSN_W-1:0]     sack_base;
      logic [SACK_BITS-1:0] sack_vector;
   } rsp_payload_type;

endpackage

// ===== sv/receive_psn_window_tracker.sv =====
// Receive-side packet sequence number tracker with a selective-ack bitmap.
//
// The req channel carries one item per packet: either a received sequence
// number or a restart command carrying a new start number. For every item
// the rsp channel returns exactly one item holding the status (new,
// duplicate, outside the window or restarted), the cumulative number, the
// expected number, the bitmap base and the low 64 bits of the received map.
//
// The result is registered: an accepted item appears on rsp in the cycle
// after. Throughput is one item per cycle unless rsp stalls; the
// classification, the bitmap update, both find-first-zero searches and the
// bitmap shift all sit in one combinational pass between the request and
// the result register. The result register is taken at the same edge as
// the next item, so req stalls only while a result is waiting and rsp is stalled.
//
// After reset the cumulative number is all ones (start number zero), the
// expected number is zero, the map is empty and unordered mode is chosen.
// ordered_mode is written over the csr port; the user writes it only while the block is idle (not enforced here).
module receive_psn_window_tracker
   import rpwt_pkg::*;
#(
   parameter int WINDOW_BITS = WINDOW_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = $clog2(WINDOW_BITS);
   localparam int CNT_W = $clog2(WINDOW_BITS + 1);
   localparam logic [WINDOW_BITS-1:0] MAP_ONE = {{(WINDOW_BITS-1){1'b0}}, 1'b1};

   // Tracking state.
   logic [PSN_W-1:0]       cum_ff, cum_in;
   logic [PSN_W-1:0]       exp_ff, exp_in;
   logic [WINDOW_BITS-1:0] map_ff, map_in;
   logic                   ordered_ff, ordered_in;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   csr_write;

   // Datapath intermediates.
   logic [PSN_W-1:0]       diff_cum;
   logic [PSN_W-1:0]       offset;
   logic [PSN_W-1:0]       diff_exp;
   logic [IDX_W-1:0]       off_idx;
   logic                   at_or_below_cum;
   logic                   in_window;
   logic                   map_hit;
   logic [WINDOW_BITS-1:0] bit_sel;
   logic [WINDOW_BITS-1:0] set_map;
   logic [WINDOW_BITS-1:0] upto_mask;
   logic [WINDOW_BITS-1:0] ord_vec;
   logic [CNT_W-1:0]       trail_ones;
   logic [CNT_W-1:0]       ord_gap;
   logic [1:0]             status;

   // A result slot is free when it is empty or being taken this cycle.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr == CSR_ORDERED_MODE_ADDR) ?
                       {{(CSR_DATA_W-1){1'b0}}, ordered_ff} : '0;

   always_comb begin
      ordered_in = ordered_ff;
      if (csr_write && csr_paddr == CSR_ORDERED_MODE_ADDR) begin
         ordered_in = csr_pwdata[0];
      end
   end

   // Classification against the cumulative number. The offset is the bit
   // position the number would take in the map; the wrap compare treats a
   // difference of zero or with the sign bit set as at or below.
   always_comb begin
      diff_cum        = req_data.psn - cum_ff;
      offset          = diff_cum - 32'd1;
      off_idx         = offset[IDX_W-1:0];
      at_or_below_cum = (diff_cum == '0) || diff_cum[PSN_W-1];
      in_window       = offset < PSN_W'(WINDOW_BITS);
      map_hit         = in_window && map_ff[off_idx];
      diff_exp        = req_data.psn - exp_ff;
   end

   // Map update and the two searches. The received bit is set first. The
   // cumulative number then moves over the run of ones at the bottom of the
   // map, and in ordered mode the expected number moves to the first hole
   // above the new packet when that packet fills the expected slot.
   always_comb begin
      bit_sel   = MAP_ONE << off_idx;
      set_map   = map_ff | bit_sel;
      // Every bit at or below the new packet's position; wraps to all ones
      // when the packet lands on the top bit.
      upto_mask = (bit_sel << 1) - MAP_ONE;
      ord_vec   = set_map | upto_mask;

      trail_ones = CNT_W'(WINDOW_BITS);
      for (int i = WINDOW_BITS - 1; i >= 0; i--) begin
         if (!set_map[i]) begin
            trail_ones = CNT_W'(i);
         end
      end

      ord_gap = CNT_W'(WINDOW_BITS);
      for (int i = WINDOW_BITS - 1; i >= 0; i--) begin
         if (!ord_vec[i]) begin
            ord_gap = CNT_W'(i);
         end
      end
   end

   // Next state and status for the accepted item.
   always_comb begin
      cum_in = cum_ff;
      exp_in = exp_ff;
      map_in = map_ff;
      status = STATUS_NEW;

      if (req_data.opcode == OPCODE_RESTART) begin
         cum_in = req_data.psn - 32'd1;
         exp_in = req_data.psn;
         map_in = '0;
         status = STATUS_RESTARTED;
      end else if (at_or_below_cum || map_hit) begin
         status = STATUS_DUPLICATE;
      end else if (!in_window) begin
         status = STATUS_OUTSIDE;
      end else begin
         status = STATUS_NEW;
         if (ordered_ff) begin
            // Only the packet that fills the expected slot moves expected on.
            if (req_data.psn == exp_ff) begin
               exp_in = cum_ff + 32'd1 + PSN_W'(ord_gap);
            end
         end else if (!diff_exp[PSN_W-1]) begin
            exp_in = req_data.psn + 32'd1;
         end
         cum_in = cum_ff + PSN_W'(trail_ones);
         map_in = set_map >> trail_ones;
      end
   end

   always_comb begin
      rsp_data_in.status         = status;
      rsp_data_in.cumulative_psn = cum_in;
      rsp_data_in.expected_psn   = exp_in;
      rsp_data_in.sack_base      = cum_in + 32'd1;
      rsp_data_in.sack_vector    = map_in[SACK_BITS-1:0];

      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cum_ff       <= '1;
         exp_ff       <= '0;
         map_ff       <= '0;
         ordered_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ordered_ff   <= ordered_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            cum_ff <= cum_in;
            exp_ff <= exp_in;
            map_ff <= map_in;
         end
      end
   end

   // The payload holds while the result waits under stall.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
